/* hw/rtl/h264_start_code_unit_splitter_assert.svh */
// assertion macros for the splitter rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef H264_START_CODE_UNIT_SPLITTER_ASSERT_SVH
`define H264_START_CODE_UNIT_SPLITTER_ASSERT_SVH

// property checked on every clock edge outside reset
`define SCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked in the cycle after the trigger, outside reset
`define SCU_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

/* hw/rtl/h264scu_pkg.sv */
// shared types, unit kind codes and header classifier for the splitter
// no dependencies
package h264scu_pkg;

  // unit kind codes as reported on the result channel
  localparam logic [2:0] KIND_IDR   = 3'd0;
  localparam logic [2:0] KIND_SPS   = 3'd1;
  localparam logic [2:0] KIND_PPS   = 3'd2;
  localparam logic [2:0] KIND_SEI   = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;

  // nal_unit_type values of interest
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_SEI = 5'd6;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [2:0] classify(input logic [7:0] hdr);
    logic [2:0] k;
    case (hdr[4:0])
      NAL_IDR: k = KIND_IDR;
      NAL_SPS: k = KIND_SPS;
      NAL_PPS: k = KIND_PPS;
      NAL_SEI: k = KIND_SEI;
      default: k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/h264scu_front.sv */
// front end: start code scan, header classification and unit bookkeeping
// depends on h264scu_pkg
module h264scu_front #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire_i,
  input  logic [7:0]             byte_i,
  input  logic                   eos_i,
  output logic                   push_o,
  output logic [2:0]             kind_o,
  output logic [OFFSET_BITS-1:0] start_o,
  output logic [OFFSET_BITS-1:0] end_o
);

  localparam int OB = OFFSET_BITS;

  logic [1:0]    zero_run_r, zero_run_nxt;
  logic          hdr_pend_r, hdr_pend_nxt;
  logic [OB-1:0] pend_start_r, pend_start_nxt;
  logic [OB-1:0] open_start_r, open_start_nxt;
  logic [2:0]    open_kind_r, open_kind_nxt;
  logic          unit_open_r, unit_open_nxt;
  logic [OB-1:0] byte_cnt_r, byte_cnt_nxt;

  logic          sc_hit;
  logic [OB-1:0] sc_start;
  logic [OB-1:0] cnt_inc;
  logic          open_aft;
  logic [2:0]    kind_aft;
  logic [OB-1:0] start_aft;
  logic          emit_sc;
  logic          emit_eos;

  always_comb begin
    sc_hit   = !hdr_pend_r && (byte_i == 8'h01) && (zero_run_r >= 2'd2);
    sc_start = OB'(byte_cnt_r - OB'(zero_run_r));
    cnt_inc  = OB'(byte_cnt_r + OB'(1));

    // unit state once this word has been taken
    if (hdr_pend_r) begin
      open_aft  = 1'b1;
      kind_aft  = h264scu_pkg::classify(byte_i);
      start_aft = pend_start_r;
    end else if (sc_hit) begin
      open_aft  = 1'b0;
      kind_aft  = open_kind_r;
      start_aft = open_start_r;
    end else begin
      open_aft  = unit_open_r;
      kind_aft  = open_kind_r;
      start_aft = open_start_r;
    end

    emit_sc  = sc_hit && unit_open_r && (open_kind_r != h264scu_pkg::KIND_SEI);
    emit_eos = eos_i && open_aft && (kind_aft != h264scu_pkg::KIND_SEI);

    push_o  = fire_i && (emit_sc || emit_eos);
    kind_o  = emit_sc ? open_kind_r  : kind_aft;
    start_o = emit_sc ? open_start_r : start_aft;
    end_o   = emit_sc ? sc_start     : cnt_inc;

    zero_run_nxt   = zero_run_r;
    hdr_pend_nxt   = hdr_pend_r;
    pend_start_nxt = pend_start_r;
    open_start_nxt = open_start_r;
    open_kind_nxt  = open_kind_r;
    unit_open_nxt  = unit_open_r;
    byte_cnt_nxt   = byte_cnt_r;

    if (fire_i) begin
      if (eos_i) begin
        // stream ends, back to the reset picture
        zero_run_nxt   = 2'd0;
        hdr_pend_nxt   = 1'b0;
        pend_start_nxt = '0;
        open_start_nxt = '0;
        open_kind_nxt  = h264scu_pkg::KIND_IDR;
        unit_open_nxt  = 1'b0;
        byte_cnt_nxt   = '0;
      end else begin
        if (byte_i == 8'h00) begin
          zero_run_nxt = (zero_run_r == 2'd3) ? 2'd3 : 2'(zero_run_r + 2'd1);
        end else begin
          zero_run_nxt = 2'd0;
        end
        hdr_pend_nxt   = sc_hit;
        if (sc_hit) begin
          pend_start_nxt = sc_start;
        end
        open_start_nxt = start_aft;
        open_kind_nxt  = kind_aft;
        unit_open_nxt  = open_aft;
        byte_cnt_nxt   = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r   <= 2'd0;
      hdr_pend_r   <= 1'b0;
      pend_start_r <= '0;
      open_start_r <= '0;
      open_kind_r  <= h264scu_pkg::KIND_IDR;
      unit_open_r  <= 1'b0;
      byte_cnt_r   <= '0;
    end else begin
      zero_run_r   <= zero_run_nxt;
      hdr_pend_r   <= hdr_pend_nxt;
      pend_start_r <= pend_start_nxt;
      open_start_r <= open_start_nxt;
      open_kind_r  <= open_kind_nxt;
      unit_open_r  <= unit_open_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
    end
  end

endmodule

/* hw/rtl/h264scu_queue.sv */
// small fifo of unit reports between the front and the back
// depends on h264scu_pkg and the assertion macro header
`include "h264_start_code_unit_splitter_assert.svh"

module h264scu_queue #(
  parameter int WIDTH = 67
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       rdata_o,
  output h264scu_pkg::q_status_t stat_o
);

  localparam int DEPTH = h264scu_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    stat_o.full  = (count_r == CNT_W'(DEPTH));
    stat_o.empty = (count_r == '0);
    rdata_o      = mem[rd_ptr_r];
    do_push = push_i && !stat_o.full;
    do_pop  = pop_i && !stat_o.empty;
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + PTR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? PTR_W'(rd_ptr_r + PTR_W'(1)) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + CNT_W'(1));
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // front must be held off while the queue is full
  `SCU_ASSERT(a_no_push_full, !(push_i && stat_o.full), "push into full queue")
  // back must not drain an empty queue
  `SCU_ASSERT(a_no_pop_empty, !(pop_i && stat_o.empty), "pop from empty queue")
  // fill level follows the pointer difference
  `SCU_ASSERT(a_count_ptrs, (PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(count_r)),
    "queue count out of step with pointers")
  // a lone push raises the fill level by one
  `SCU_ASSERT_NEXT(a_push_count, (do_push && !do_pop),
    (count_r == CNT_W'($past(count_r) + CNT_W'(1))), "push did not raise count")

endmodule

/* hw/rtl/h264scu_back.sv */
// back end: length computation, saturation and the output register
// depends on h264scu_pkg
module h264scu_back #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  h264scu_pkg::q_status_t q_stat_i,
  input  logic [2:0]             q_kind_i,
  input  logic [OFFSET_BITS-1:0] q_start_i,
  input  logic [OFFSET_BITS-1:0] q_end_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             out_kind_o,
  output logic [31:0]            out_offset_o,
  output logic [31:0]            out_length_o
);

  localparam int OB = OFFSET_BITS;
  localparam logic [OB-1:0] SatLim = OB'(64'h0000_0000_FFFF_FFFF);

  logic          valid_r, valid_nxt;
  logic [2:0]    kind_r;
  logic [31:0]   offset_r;
  logic [31:0]   length_r;
  logic [OB-1:0] len_raw;
  logic [31:0]   len_sat;

  always_comb begin
    pop_o     = !q_stat_i.empty && (!valid_r || out_ready_i);
    len_raw   = OB'(q_end_i - q_start_i);
    len_sat   = (len_raw > SatLim) ? 32'hFFFF_FFFF : 32'(len_raw);
    valid_nxt = pop_o ? 1'b1 : (out_ready_i ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      kind_r   <= q_kind_i;
      offset_r <= 32'(q_start_i);
      length_r <= len_sat;
    end
  end

  assign out_valid_o  = valid_r;
  assign out_kind_o   = kind_r;
  assign out_offset_o = offset_r;
  assign out_length_o = length_r;

endmodule

/* hw/rtl/h264_start_code_unit_splitter.sv */
// top level of the annex b start code unit splitter
// depends on h264scu_pkg, h264scu_front, h264scu_queue and h264scu_back
//
//  channel | dir | payload                                   | end mark
//  in_     | in  | tdata[7:0] stream byte                    | tlast end of stream
//  out_    | out | tdata[31:0] offset, tdata[63:32] length   | tlast last result
//          |     | tuser[2:0] unit kind                      |
//
// one input word per clock while the report queue is not full; the scanner decides
// in the cycle of the accept, so throughput is set by the four-entry report queue
// and the output register, which drain one report per clock while out_ is ready.
// each report is registered in the queue, then in the output register, before out_.
// reset is synchronous, active low, and clears scanner state, queue and output valid.
// in_tready drops only while the report queue is full; out_ stalls fill the queue.
module h264_start_code_unit_splitter #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] unit_offset, [63:32] unit_length
  output logic [2:0]  out_tuser,  // [2:0] unit_kind
  output logic        out_tlast   // last_result
);

  localparam int OB    = OFFSET_BITS;
  localparam int QW    = 3 + 2 * OB;

  logic                   in_fire;
  logic                   f_push;
  logic [2:0]             f_kind;
  logic [OB-1:0]          f_start;
  logic [OB-1:0]          f_end;
  logic [QW-1:0]          q_rdata;
  logic                   b_pop;
  h264scu_pkg::q_status_t q_stat;
  logic [31:0]            o_offset;
  logic [31:0]            o_length;

  // accept whenever the queue has room for a possible report
  assign in_tready = !q_stat.full;
  assign in_fire   = in_tvalid && in_tready;

  h264scu_front #(.OFFSET_BITS(OB)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire_i  (in_fire),
    .byte_i  (in_tdata),
    .eos_i   (in_tlast),
    .push_o  (f_push),
    .kind_o  (f_kind),
    .start_o (f_start),
    .end_o   (f_end)
  );

  // entry layout: kind on top, then unit start, then unit end
  h264scu_queue #(.WIDTH(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .wdata_i ({f_kind, f_start, f_end}),
    .pop_i   (b_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  h264scu_back #(.OFFSET_BITS(OB)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat_i     (q_stat),
    .q_kind_i     (q_rdata[QW-1 -: 3]),
    .q_start_i    (q_rdata[2*OB-1 -: OB]),
    .q_end_i      (q_rdata[OB-1:0]),
    .pop_o        (b_pop),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_kind_o   (out_tuser),
    .out_offset_o (o_offset),
    .out_length_o (o_length)
  );

  assign out_tdata = {o_length, o_offset};
  // a word closes at most one unit, so every report is the last of its word
  assign out_tlast = 1'b1;

endmodule
